/* design/dlpi_pkg.sv */
// ----------------------------------------------------------------------------
// dlpi_pkg
// Shared types and constants for the line-number program interpreter.
// ----------------------------------------------------------------------------
package dlpi_pkg;

  // Parse phases of the byte stream
  typedef enum logic [3:0] {
    PH_OP       = 4'd0,
    PH_ADV_PC   = 4'd1,
    PH_ADV_LINE = 4'd2,
    PH_FILE     = 4'd3,
    PH_COLUMN   = 4'd4,
    PH_ISA      = 4'd5,
    PH_FIXED    = 4'd6,
    PH_EXT_LEN  = 4'd7,
    PH_EXT_OP   = 4'd8,
    PH_SET_ADDR = 4'd9,
    PH_DISCR    = 4'd10,
    PH_SKIP     = 4'd11
  } phase_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NEG_LINE = 3'd1;
  localparam logic [2:0] ERR_BAD_STD  = 3'd2;
  localparam logic [2:0] ERR_BAD_EXT  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Standard opcodes
  localparam logic [7:0] OP_EXTENDED     = 8'd0;
  localparam logic [7:0] OP_COPY         = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC   = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE = 8'd3;
  localparam logic [7:0] OP_SET_FILE     = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN   = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT  = 8'd6;
  localparam logic [7:0] OP_BASIC_BLOCK  = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV_PC = 8'd9;
  localparam logic [7:0] OP_PROLOGUE_END = 8'd10;
  localparam logic [7:0] OP_EPILOGUE_BEG = 8'd11;
  localparam logic [7:0] OP_SET_ISA      = 8'd12;

  // Extended sub-opcodes
  localparam logic [7:0] XOP_END_SEQ  = 8'd1;
  localparam logic [7:0] XOP_SET_ADDR = 8'd2;
  localparam logic [7:0] XOP_SET_DISC = 8'd4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_OPCODE_BASE = 2'd0;
  localparam logic [1:0] REG_LINE_BASE   = 2'd1;
  localparam logic [1:0] REG_LINE_RANGE  = 2'd2;
  localparam logic [1:0] REG_DEF_STMT    = 2'd3;

  localparam logic [7:0] CONST_ADD_TOP = 8'd255;

  typedef struct packed {
    logic [7:0] opcode_base;
    logic [7:0] line_base;
    logic [7:0] line_range;
    logic       default_is_stmt;
  } cfg_t;

  typedef struct packed {
    logic load_byte;
    logic div_start;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_busy;
  } sts_t;

endpackage

/* design/dlpi_ctrl.sv */
// ----------------------------------------------------------------------------
// dlpi_ctrl
// Sequencer: take a byte, run the divider when needed, commit the step.
// ----------------------------------------------------------------------------
module dlpi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dlpi_pkg::sts_t sts_i,
  output dlpi_pkg::cmd_t cmd_o
);
  import dlpi_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.needs_div) state_d = ST_DIV;
        else if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      ST_DIV:  if (cnt_q == 2'd3) state_d = ST_FIN;
      ST_FIN:  if (!sts_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_byte = in_valid_i;
      end
      ST_EXEC: begin
        if (sts_i.needs_div) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
        end else begin
          cmd_o.commit = !sts_i.out_busy;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 2'd1;
      end
      ST_FIN:  cmd_o.commit = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* design/dlpi_dpath.sv */
// ----------------------------------------------------------------------------
// dlpi_dpath
// Line state registers, operand assembly, radix-4 divider and row register.
// ----------------------------------------------------------------------------
module dlpi_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dlpi_pkg::cfg_t  cfg_i,
  input  dlpi_pkg::cmd_t  cmd_i,
  output dlpi_pkg::sts_t  sts_o,
  input  logic [7:0]     prog_byte_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [63:0]    row_address_o,
  output logic [31:0]    row_file_o,
  output logic [31:0]    row_line_o,
  output logic [31:0]    row_column_o,
  output logic [31:0]    row_discriminator_o,
  output logic           row_is_stmt_o,
  output logic           row_basic_block_o,
  output logic           row_end_sequence_o,
  output logic           row_prologue_end_o,
  output logic           row_epilogue_begin_o,
  output logic [2:0]     error_code_o
);
  import dlpi_pkg::*;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // line state
  logic [63:0] addr_q, addr_d;
  logic [31:0] file_q, file_d, line_q, line_d, col_q, col_d, disc_q, disc_d;
  logic [3:0]  flags_q, flags_d;
  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [7:0]  byte_q;

  // divider
  logic [7:0] quot_q, quot_d, rem_q, rem_d, divisor;
  logic [8:0] trial;

  // row register
  logic        oval_q, oval_d;
  logic [63:0] o_addr_q;
  logic [31:0] o_file_q, o_line_q, o_col_q, o_disc_q;
  logic [3:0]  o_flags_q;
  logic        o_end_q;
  logic [2:0]  o_err_q;

  // step results
  logic        emit, emit_end;
  logic [2:0]  err;
  logic        is_spec;
  logic [6:0]  p7;
  logic        leb_sgn, leb_ovf, leb_done;
  logic [63:0] acc_n, mag;
  logic signed [33:0] nl;

  assign divisor   = (cfg_i.line_range == 8'd0) ? 8'd1 : cfg_i.line_range;
  assign is_spec   = byte_q >= cfg_i.opcode_base;
  assign sts_o.needs_div = (phase_q == PH_OP) && (is_spec || byte_q == OP_CONST_ADD_PC);
  assign sts_o.out_busy  = oval_q && out_stall_i;

  // Two quotient bits per step, four steps per divide
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    trial  = '0;
    if (cmd_i.div_start) begin
      quot_d = is_spec ? byte_q - cfg_i.opcode_base : CONST_ADD_TOP - cfg_i.opcode_base;
      rem_d  = '0;
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 2; k++) begin
        trial = {rem_d, quot_d[7]};
        quot_d = {quot_d[6:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial     = trial - {1'b0, divisor};
          quot_d[0] = 1'b1;
        end
        rem_d = trial[7:0];
      end
    end
  end

  // One program byte
  always_comb begin
    addr_d   = addr_q;
    file_d   = file_q;
    line_d   = line_q;
    col_d    = col_q;
    disc_d   = disc_q;
    flags_d  = flags_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    shift_d  = shift_q;
    emit     = 1'b0;
    emit_end = 1'b0;
    err      = ERR_NONE;
    p7       = byte_q[6:0];
    leb_sgn  = phase_q == PH_ADV_LINE;
    leb_ovf  = 1'b0;
    leb_done = 1'b0;
    acc_n    = acc_q;
    mag      = '0;
    nl       = $signed({2'b00, line_q}) + $signed({{26{cfg_i.line_base[7]}}, cfg_i.line_base})
             + $signed({26'd0, rem_q});
    unique case (phase_q)
      PH_OP: begin
        if (is_spec) begin
          if (nl[33]) err = ERR_NEG_LINE;
          else if (nl[32]) err = ERR_OVERFLOW;
          else begin
            addr_d  = addr_q + {56'd0, quot_q};
            line_d  = nl[31:0];
            emit    = 1'b1;
            flags_d = {3'b000, flags_q[0]};
            disc_d  = '0;
          end
        end else if (byte_q == OP_EXTENDED) begin
          phase_d = PH_EXT_LEN; acc_d = '0; shift_d = '0;
        end else begin
          unique case (byte_q)
            OP_COPY: begin
              emit = 1'b1; flags_d = {3'b000, flags_q[0]}; disc_d = '0;
            end
            OP_ADVANCE_PC:   begin phase_d = PH_ADV_PC;   acc_d = '0; shift_d = '0; end
            OP_ADVANCE_LINE: begin phase_d = PH_ADV_LINE; acc_d = '0; shift_d = '0; end
            OP_SET_FILE:     begin phase_d = PH_FILE;     acc_d = '0; shift_d = '0; end
            OP_SET_COLUMN:   begin phase_d = PH_COLUMN;   acc_d = '0; shift_d = '0; end
            OP_NEGATE_STMT:  flags_d[0] = ~flags_q[0];
            OP_BASIC_BLOCK:  flags_d[1] = 1'b1;
            OP_CONST_ADD_PC: addr_d = addr_q + {56'd0, quot_q};
            OP_FIXED_ADV_PC: begin phase_d = PH_FIXED;    acc_d = '0; shift_d = '0; end
            OP_PROLOGUE_END: flags_d[2] = 1'b1;
            OP_EPILOGUE_BEG: flags_d[3] = 1'b1;
            OP_SET_ISA:      begin phase_d = PH_ISA;      acc_d = '0; shift_d = '0; end
            default:         err = ERR_BAD_STD;
          endcase
        end
      end
      PH_ADV_PC, PH_ADV_LINE, PH_FILE, PH_COLUMN, PH_ISA, PH_EXT_LEN, PH_DISCR: begin
        if (shift_q >= 7'd63) begin
          if ((leb_sgn ? !(p7 == 7'h00 || p7 == 7'h7f) : (p7 > 7'd1)) || byte_q[7])
            leb_ovf = 1'b1;
          else begin
            acc_n    = acc_q | {p7[0], 63'd0};
            leb_done = 1'b1;
          end
        end else begin
          acc_n = acc_q | ({57'd0, p7} << shift_q[5:0]);
          if (byte_q[7]) shift_d = shift_q + 7'd7;
          else begin
            leb_done = 1'b1;
            if (leb_sgn && p7[6] && (shift_q + 7'd7 < 7'd64))
              acc_n = acc_n | ({64{1'b1}} << (shift_q + 7'd7));
          end
        end
        acc_d = acc_n;
        if (leb_ovf) begin
          phase_d = byte_q[7] ? PH_SKIP : PH_OP;
          err     = ERR_OVERFLOW;
        end else if (leb_done) begin
          phase_d = PH_OP;
          mag     = ~acc_n + 64'd1;
          unique case (phase_q)
            PH_ADV_PC: addr_d = addr_q + acc_n;
            PH_ADV_LINE: begin
              if (acc_n[63]) begin
                if (mag > {32'd0, line_q}) err = ERR_NEG_LINE;
                else line_d = line_q - mag[31:0];
              end else begin
                if (acc_n > {32'd0, MAX32 - line_q}) err = ERR_OVERFLOW;
                else line_d = line_q + acc_n[31:0];
              end
            end
            PH_FILE:   if (acc_n[63:32] != '0) err = ERR_OVERFLOW; else file_d = acc_n[31:0];
            PH_COLUMN: if (acc_n[63:32] != '0) err = ERR_OVERFLOW; else col_d = acc_n[31:0];
            PH_DISCR:  if (acc_n[63:32] != '0) err = ERR_OVERFLOW; else disc_d = acc_n[31:0];
            PH_EXT_LEN: phase_d = PH_EXT_OP;
            default: phase_d = PH_OP;
          endcase
        end
      end
      PH_FIXED: begin
        acc_n = acc_q | ({56'd0, byte_q} << (shift_q & 7'd8));
        acc_d = acc_n;
        if (shift_q >= 7'd8) begin
          addr_d = addr_q + acc_n; phase_d = PH_OP;
        end else shift_d = 7'd8;
      end
      PH_SET_ADDR: begin
        acc_n = acc_q | ({56'd0, byte_q} << shift_q[5:0]);
        acc_d = acc_n;
        if (shift_q >= 7'd56) begin
          addr_d = acc_n; phase_d = PH_OP;
        end else shift_d = shift_q + 7'd8;
      end
      PH_EXT_OP: begin
        phase_d = PH_OP;
        unique case (byte_q)
          XOP_END_SEQ: begin
            emit = 1'b1; emit_end = 1'b1;
            addr_d = '0; file_d = 32'd1; line_d = 32'd1; col_d = '0; disc_d = '0;
            flags_d = {3'b000, cfg_i.default_is_stmt};
          end
          XOP_SET_ADDR: begin phase_d = PH_SET_ADDR; acc_d = '0; shift_d = '0; end
          XOP_SET_DISC: begin phase_d = PH_DISCR;    acc_d = '0; shift_d = '0; end
          default:      err = ERR_BAD_EXT;
        endcase
      end
      PH_SKIP: if (!byte_q[7]) phase_d = PH_OP;
      default: phase_d = PH_OP;
    endcase
    // a failing opcode leaves the line state alone
    if (err != ERR_NONE) begin
      addr_d = addr_q; file_d = file_q; line_d = line_q; col_d = col_q;
      disc_d = disc_q; flags_d = flags_q;
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (cmd_i.commit && (emit || err != ERR_NONE)) oval_d = 1'b1;
    else if (!out_stall_i) oval_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      file_q  <= 32'd1;
      line_q  <= 32'd1;
      col_q   <= '0;
      disc_q  <= '0;
      flags_q <= 4'b0001;
      phase_q <= PH_OP;
      acc_q   <= '0;
      shift_q <= '0;
      oval_q  <= 1'b0;
    end else begin
      oval_q <= oval_d;
      if (cmd_i.commit) begin
        addr_q  <= addr_d;
        file_q  <= file_d;
        line_q  <= line_d;
        col_q   <= col_d;
        disc_q  <= disc_d;
        flags_q <= flags_d;
        phase_q <= phase_d;
        acc_q   <= acc_d;
        shift_q <= shift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) byte_q <= prog_byte_i;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (cmd_i.commit && (emit || err != ERR_NONE)) begin
      if (err != ERR_NONE) begin
        o_addr_q <= '0; o_file_q <= '0; o_line_q <= '0; o_col_q <= '0;
        o_disc_q <= '0; o_flags_q <= '0; o_end_q <= 1'b0;
      end else begin
        // row shows the updated address and line, flags before clearing
        o_addr_q  <= is_spec && phase_q == PH_OP ? addr_d : addr_q;
        o_line_q  <= is_spec && phase_q == PH_OP ? line_d : line_q;
        o_file_q  <= file_q;
        o_col_q   <= col_q;
        o_disc_q  <= disc_q;
        o_flags_q <= flags_q;
        o_end_q   <= emit_end;
      end
      o_err_q <= err;
    end
  end

  assign out_valid_o          = oval_q;
  assign row_address_o        = o_addr_q;
  assign row_file_o           = o_file_q;
  assign row_line_o           = o_line_q;
  assign row_column_o         = o_col_q;
  assign row_discriminator_o  = o_disc_q;
  assign row_is_stmt_o        = o_flags_q[0];
  assign row_basic_block_o    = o_flags_q[1];
  assign row_prologue_end_o   = o_flags_q[2];
  assign row_epilogue_begin_o = o_flags_q[3];
  assign row_end_sequence_o   = o_end_q;
  assign error_code_o         = o_err_q;

endmodule

/* design/dwarf_line_program_interpreter.sv */
// ----------------------------------------------------------------------------
// dwarf_line_program_interpreter
// Line-number program interpreter, one program byte per input beat.
// ----------------------------------------------------------------------------
// Feed the program on prog_byte_i with in_valid_i; a beat is taken at an edge
// where in_valid_i is high and in_stall_o low. Each byte either advances the
// operand being assembled or executes an opcode. A row beat (or an error beat,
// error_code_o nonzero, all row fields zero) leaves on the out_ channel for
// special opcodes, copy, end of sequence and failing opcodes.
// Each byte is first accepted, then executed. Special opcodes and
// const_add_pc also wait for the 8-bit divide by line_range in a radix-4
// unit that runs four steps. A result appears in the cycle after execution.
// A finished row waits in the output register while the next byte is taken;
// if the receiver stalls while that register is still full, the step of the
// next byte holds, whether or not it makes a result, and input beats stall
// until the register drains.
// Reset returns the line state to its initial values and the registers to
// their defaults; no clearing pass is needed. The user must write registers
// over the APB port only while the block is idle (not enforced by the block):
// opcode_base at 0x0, line_base at 0x4, line_range at 0x8, default_is_stmt at 0xC.
// ----------------------------------------------------------------------------
module dwarf_line_program_interpreter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  prog_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] row_address_o,
  output logic [31:0] row_file_o,
  output logic [31:0] row_line_o,
  output logic [31:0] row_column_o,
  output logic [31:0] row_discriminator_o,
  output logic        row_is_stmt_o,
  output logic        row_basic_block_o,
  output logic        row_end_sequence_o,
  output logic        row_prologue_end_o,
  output logic        row_epilogue_begin_o,
  output logic [2:0]  error_code_o
);
  import dlpi_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Hold the header registers; take a write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.opcode_base     <= 8'd13;
      cfg_q.line_base       <= 8'hFB;
      cfg_q.line_range      <= 8'd14;
      cfg_q.default_is_stmt <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_OPCODE_BASE: cfg_q.opcode_base     <= pwdata[7:0];
        REG_LINE_BASE:   cfg_q.line_base       <= pwdata[7:0];
        REG_LINE_RANGE:  cfg_q.line_range      <= pwdata[7:0];
        REG_DEF_STMT:    cfg_q.default_is_stmt <= pwdata[0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OPCODE_BASE: prdata = {24'd0, cfg_q.opcode_base};
      REG_LINE_BASE:   prdata = {24'd0, cfg_q.line_base};
      REG_LINE_RANGE:  prdata = {24'd0, cfg_q.line_range};
      REG_DEF_STMT:    prdata = {31'd0, cfg_q.default_is_stmt};
      default:         prdata = '0;
    endcase
  end

  dlpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpi_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .prog_byte_i          (prog_byte_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .row_address_o        (row_address_o),
    .row_file_o           (row_file_o),
    .row_line_o           (row_line_o),
    .row_column_o         (row_column_o),
    .row_discriminator_o  (row_discriminator_o),
    .row_is_stmt_o        (row_is_stmt_o),
    .row_basic_block_o    (row_basic_block_o),
    .row_end_sequence_o   (row_end_sequence_o),
    .row_prologue_end_o   (row_prologue_end_o),
    .row_epilogue_begin_o (row_epilogue_begin_o),
    .error_code_o         (error_code_o)
  );

endmodule
